@@ sv/assert_macros.svh @@
// assertion macros shared by the go-back-n sender modules
// expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GBN_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the following cycle
`define GBN_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// expression holds at every clock edge
`define GBN_ASSERT_ALW(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

`endif

@@ sv/gbn_pkg.sv @@
// shared constants, codes and types for the go-back-n sender window
// no dependencies
package gbn_pkg;

   // parameter defaults
   localparam int SeqCountDef     = 8;
   localparam int PayloadWidthDef = 32;

   // fixed port field widths
   localparam int PortPayloadWidth = 32;
   localparam int SeqPortWidth     = 3;
   localparam int WindowWidth      = 3;
   localparam int ReplayCntWidth   = 3;
   localparam int MaxReplay        = 7;

   localparam logic [WindowWidth-1:0] WindowReset = 3'd4;

   // request codes
   localparam logic [1:0] ReqSend    = 2'd0;
   localparam logic [1:0] ReqAck     = 2'd1;
   localparam logic [1:0] ReqTimeout = 2'd2;
   localparam logic [1:0] ReqNone    = 2'd3;

   // timer commands
   localparam logic [1:0] TmrNone    = 2'd0;
   localparam logic [1:0] TmrStart   = 2'd1;
   localparam logic [1:0] TmrRestart = 2'd2;
   localparam logic [1:0] TmrStop    = 2'd3;

   // register file
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic RegWindowSize = 1'b0;

   typedef enum logic [1:0] {
      StIdle,
      StRead,
      StEmit
   } gbn_state_type;

   typedef struct packed {
      logic exec_single;
      logic drop;
      logic rep_init;
      logic rd_issue;
      logic emit_replay;
   } gbn_cmd_type;

   typedef struct packed {
      logic pending;
      logic is_timeout;
      logic is_none;
      logic out_free;
      logic none_outstanding;
      logic replay_last;
   } gbn_status_type;

endpackage

@@ sv/gbn_req_if.sv @@
// request channel: valid/ready handshake carrying one request item
// depends on gbn_pkg
interface gbn_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              req_type;
   logic [gbn_pkg::PortPayloadWidth-1:0]    payload;
   logic [gbn_pkg::SeqPortWidth-1:0]        ack_number;
   logic                                    ack_checksum_ok;

   modport source (output valid, req_type, payload, ack_number, ack_checksum_ok,
                   input ready);
   modport sink (input valid, req_type, payload, ack_number, ack_checksum_ok,
                 output ready);
endinterface

@@ sv/gbn_rsp_if.sv @@
// result channel: valid/ready handshake carrying one result item
// depends on gbn_pkg
interface gbn_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    accepted;
   logic                                    packet_valid;
   logic [gbn_pkg::SeqPortWidth-1:0]        packet_seq;
   logic [gbn_pkg::PortPayloadWidth-1:0]    packet_payload;
   logic [1:0]                              timer_cmd;
   logic                                    last;

   modport source (output valid, accepted, packet_valid, packet_seq, packet_payload,
                   timer_cmd, last, input ready);
   modport sink (input valid, accepted, packet_valid, packet_seq, packet_payload,
                 timer_cmd, last, output ready);
endinterface

@@ sv/gbn_csr.sv @@
// register port holding the window size
// depends on gbn_pkg
module gbn_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gbn_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  logic [gbn_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic [gbn_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                 csr_pready,
   output logic [gbn_pkg::WindowWidth-1:0]      window_size
);

   logic [gbn_pkg::WindowWidth-1:0] window_ff;
   logic [gbn_pkg::WindowWidth-1:0] window_in;
   logic                            reg_idx;
   logic                            wr_en;

   assign reg_idx    = csr_paddr[gbn_pkg::CsrAddrWidth-1];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // write decode
   always_comb begin
      window_in = window_ff;
      if (wr_en) begin
         unique case (reg_idx)
            gbn_pkg::RegWindowSize: window_in = csr_pwdata[gbn_pkg::WindowWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= gbn_pkg::WindowReset;
      end else begin
         window_ff <= window_in;
      end
   end

   // read decode
   always_comb begin
      unique case (reg_idx)
         gbn_pkg::RegWindowSize: csr_prdata = gbn_pkg::CsrDataWidth'(window_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign window_size = window_ff;

endmodule

@@ sv/gbn_ctrl.sv @@
// controller state machine: sequences single results and timeout replays
// depends on gbn_pkg and assert_macros.svh
`include "assert_macros.svh"

module gbn_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  gbn_pkg::gbn_status_type  status,
   output gbn_pkg::gbn_cmd_type     cmd
);

   gbn_pkg::gbn_state_type state_ff;
   gbn_pkg::gbn_state_type state_in;
   logic                   start_replay;

   assign start_replay = status.pending & status.is_timeout & ~status.none_outstanding;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbn_pkg::StIdle: begin
            if (start_replay) state_in = gbn_pkg::StRead;
         end
         gbn_pkg::StRead: begin
            state_in = gbn_pkg::StEmit;
         end
         gbn_pkg::StEmit: begin
            if (status.out_free) begin
               state_in = status.replay_last ? gbn_pkg::StIdle : gbn_pkg::StRead;
            end
         end
         default: state_in = gbn_pkg::StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbn_pkg::StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   // command outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         gbn_pkg::StIdle: begin
            if (status.pending) begin
               if (status.is_none) begin
                  cmd.drop = 1'b1;
               end else if (start_replay) begin
                  cmd.rep_init = 1'b1;
               end else if (status.out_free) begin
                  cmd.exec_single = 1'b1;
               end
            end
         end
         gbn_pkg::StRead: cmd.rd_issue = 1'b1;
         gbn_pkg::StEmit: cmd.emit_replay = status.out_free;
         default: ;
      endcase
   end

   `GBN_ASSERT_ALW(a_cmd_onehot, $onehot0(cmd), "more than one command at once")
   `GBN_ASSERT_IMP(a_replay_needs_timeout, state_ff != gbn_pkg::StIdle, status.pending && status.is_timeout, "replay running without a pending timeout item")
   `GBN_ASSERT_NXT(a_read_then_emit, cmd.rd_issue, state_ff == gbn_pkg::StEmit, "read not followed by emit")

endmodule

@@ sv/gbn_datapath.sv @@
// datapath: request holding register, window pointers, packet store and result register
// depends on gbn_pkg, gbn_req_if, gbn_rsp_if and assert_macros.svh
`include "assert_macros.svh"

module gbn_datapath #(
   parameter int SEQ_COUNT     = gbn_pkg::SeqCountDef,
   parameter int PAYLOAD_WIDTH = gbn_pkg::PayloadWidthDef
) (
   input  logic                              clock,
   input  logic                              reset,
   gbn_req_if.sink                           req_if,
   gbn_rsp_if.source                         rsp_if,
   input  logic [gbn_pkg::WindowWidth-1:0]   window_size,
   input  gbn_pkg::gbn_cmd_type              cmd,
   output gbn_pkg::gbn_status_type           status
);

   localparam int SW = $clog2(SEQ_COUNT);
   localparam int XW = SW + gbn_pkg::SeqPortWidth;
   localparam int WW = PAYLOAD_WIDTH + gbn_pkg::PortPayloadWidth;
   localparam int PW = gbn_pkg::PortPayloadWidth;
   localparam int RW = gbn_pkg::ReplayCntWidth;
   localparam logic [SW-1:0] SeqLast    = SW'(SEQ_COUNT - 1);
   localparam logic [SW:0]   SeqMod     = (SW + 1)'(SEQ_COUNT);
   localparam logic [XW-1:0] SeqModX    = XW'(SEQ_COUNT);
   localparam logic [XW-1:0] SeqLastX   = XW'(SEQ_COUNT - 1);
   localparam logic [XW-1:0] MaxReplayX = XW'(gbn_pkg::MaxReplay);

   // holding register for one request item
   logic                           pending_ff;
   logic                           pending_in;
   logic [1:0]                     hold_type_ff;
   logic [PAYLOAD_WIDTH-1:0]       hold_pay_ff;
   logic [gbn_pkg::SeqPortWidth-1:0] hold_ack_ff;
   logic                           hold_ok_ff;
   logic                           accept;
   logic                           clear;

   // window state
   logic [SW-1:0]                  base_ff;
   logic [SW-1:0]                  base_in;
   logic [SW-1:0]                  next_seq_ff;
   logic [SW-1:0]                  next_seq_in;
   logic [RW-1:0]                  rep_cnt_ff;
   logic [RW-1:0]                  rep_cnt_in;

   // packet store
   logic [PAYLOAD_WIDTH-1:0]       packet_store_ff [SEQ_COUNT];
   logic [PAYLOAD_WIDTH-1:0]       packet_rd_ff;
   logic [PAYLOAD_WIDTH-1:0]       wr_pay;
   logic                           mem_we;

   // result register
   logic                           rsp_valid_ff;
   logic                           acc_ff;
   logic                           pv_ff;
   logic [gbn_pkg::SeqPortWidth-1:0] seq_ff;
   logic [PW-1:0]                  pay_ff;
   logic [1:0]                     tcmd_ff;
   logic                           last_ff;
   logic                           load;
   logic                           out_free;

   // combinational helpers
   logic [WW-1:0]                  in_wide;
   logic [WW-1:0]                  rd_wide;
   logic [SW:0]                    out_diff;
   logic [SW:0]                    out_wrap;
   logic [SW-1:0]                  outstanding;
   logic [XW-1:0]                  out_x;
   logic [XW-1:0]                  win_x;
   logic [XW-1:0]                  eff_win;
   logic                           send_ok;
   logic [SW-1:0]                  next_inc;
   logic [XW-1:0]                  ack_x;
   logic [SW-1:0]                  ack_seq;
   logic [SW:0]                    ack_diff;
   logic [SW:0]                    ack_wrap;
   logic [SW-1:0]                  ack_dist;
   logic                           ack_take;
   logic [SW-1:0]                  ack_base;
   logic [XW-1:0]                  rep_sum;
   logic [SW-1:0]                  rep_addr;
   logic [XW-1:0]                  replay_n;
   logic                           replay_last;
   logic [XW-1:0]                  next_x;
   logic [XW-1:0]                  rep_x;
   logic                           s_acc;
   logic                           s_pv;
   logic [gbn_pkg::SeqPortWidth-1:0] s_seq;
   logic [PW-1:0]                  s_pay;
   logic [1:0]                     s_tcmd;

   // payload of the held item as seen on the result port
   function automatic logic [PW-1:0] in_wide_hold(input logic [PAYLOAD_WIDTH-1:0] p);
      logic [WW-1:0] w;
      w = WW'(p);
      return w[PW-1:0];
   endfunction

   // accept into the holding register
   assign req_if.ready = ~pending_ff;
   assign accept       = req_if.valid & ~pending_ff;
   assign clear        = cmd.exec_single | cmd.drop | (cmd.emit_replay & replay_last);

   always_comb begin
      pending_in = pending_ff;
      if (accept) begin
         pending_in = 1'b1;
      end else if (clear) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assign in_wide = WW'(req_if.payload);

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_type_ff <= req_if.req_type;
         hold_pay_ff  <= in_wide[PAYLOAD_WIDTH-1:0];
         hold_ack_ff  <= req_if.ack_number;
         hold_ok_ff   <= req_if.ack_checksum_ok;
      end
   end

   // outstanding count modulo the sequence space
   assign out_diff    = {1'b0, next_seq_ff} - {1'b0, base_ff};
   assign out_wrap    = out_diff + SeqMod;
   assign outstanding = out_diff[SW] ? out_wrap[SW-1:0] : out_diff[SW-1:0];
   assign out_x       = XW'(outstanding);

   // effective window and send check
   assign win_x    = XW'(window_size);
   assign eff_win  = (win_x > SeqLastX) ? SeqLastX : win_x;
   assign send_ok  = out_x < eff_win;
   assign next_inc = (next_seq_ff == SeqLast) ? '0 : next_seq_ff + SW'(1);
   assign next_x   = XW'(next_seq_ff);

   // ack check: number must lie among the outstanding ones
   assign ack_x    = XW'(hold_ack_ff);
   assign ack_seq  = SW'(ack_x);
   assign ack_diff = {1'b0, ack_seq} - {1'b0, base_ff};
   assign ack_wrap = ack_diff + SeqMod;
   assign ack_dist = ack_diff[SW] ? ack_wrap[SW-1:0] : ack_diff[SW-1:0];
   assign ack_take = hold_ok_ff & (ack_x < SeqModX) & (XW'(ack_dist) < out_x);
   assign ack_base = (ack_seq == SeqLast) ? '0 : ack_seq + SW'(1);

   // replay address and count
   assign rep_sum     = XW'(base_ff) + XW'(rep_cnt_ff);
   assign rep_addr    = (rep_sum >= SeqModX) ? SW'(rep_sum - SeqModX) : SW'(rep_sum);
   assign rep_x       = XW'(rep_addr);
   assign replay_n    = (out_x > MaxReplayX) ? MaxReplayX : out_x;
   assign replay_last = (XW'(rep_cnt_ff) + XW'(1)) == replay_n;

   // single-result items: send, ack, timeout with nothing outstanding
   always_comb begin
      s_acc       = 1'b0;
      s_pv        = 1'b0;
      s_seq       = '0;
      s_pay       = '0;
      s_tcmd      = gbn_pkg::TmrNone;
      mem_we      = 1'b0;
      base_in     = base_ff;
      next_seq_in = next_seq_ff;
      case (hold_type_ff)
         gbn_pkg::ReqSend: begin
            if (send_ok) begin
               s_acc  = 1'b1;
               s_pv   = 1'b1;
               s_seq  = next_x[gbn_pkg::SeqPortWidth-1:0];
               s_pay  = in_wide_hold(hold_pay_ff);
               s_tcmd = (base_ff == next_seq_ff) ? gbn_pkg::TmrStart : gbn_pkg::TmrNone;
               mem_we = cmd.exec_single;
               if (cmd.exec_single) next_seq_in = next_inc;
            end
         end
         gbn_pkg::ReqAck: begin
            if (ack_take) begin
               s_tcmd = (ack_base == next_seq_ff) ? gbn_pkg::TmrStop : gbn_pkg::TmrRestart;
               if (cmd.exec_single) base_in = ack_base;
            end
         end
         gbn_pkg::ReqTimeout: s_tcmd = gbn_pkg::TmrStop;
         default: ;
      endcase
   end

   always_comb begin
      rep_cnt_in = rep_cnt_ff;
      if (cmd.rep_init) begin
         rep_cnt_in = '0;
      end else if (cmd.emit_replay) begin
         rep_cnt_in = rep_cnt_ff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         next_seq_ff <= '0;
         rep_cnt_ff  <= '0;
      end else begin
         base_ff     <= base_in;
         next_seq_ff <= next_seq_in;
         rep_cnt_ff  <= rep_cnt_in;
      end
   end

   // packet store, one write and one registered read port
   assign wr_pay = hold_pay_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         packet_store_ff[next_seq_ff] <= wr_pay;
      end
      if (cmd.rd_issue) begin
         packet_rd_ff <= packet_store_ff[rep_addr];
      end
   end

   assign rd_wide = WW'(packet_rd_ff);

   // result register
   assign out_free = ~rsp_valid_ff | rsp_if.ready;
   assign load     = cmd.exec_single | cmd.emit_replay;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_single) begin
         acc_ff  <= s_acc;
         pv_ff   <= s_pv;
         seq_ff  <= s_seq;
         pay_ff  <= s_pay;
         tcmd_ff <= s_tcmd;
         last_ff <= 1'b1;
      end else if (cmd.emit_replay) begin
         acc_ff  <= 1'b0;
         pv_ff   <= 1'b1;
         seq_ff  <= rep_x[gbn_pkg::SeqPortWidth-1:0];
         pay_ff  <= rd_wide[PW-1:0];
         tcmd_ff <= replay_last ? gbn_pkg::TmrRestart : gbn_pkg::TmrNone;
         last_ff <= replay_last;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.accepted       = acc_ff;
   assign rsp_if.packet_valid   = pv_ff;
   assign rsp_if.packet_seq     = seq_ff;
   assign rsp_if.packet_payload = pay_ff;
   assign rsp_if.timer_cmd      = tcmd_ff;
   assign rsp_if.last           = last_ff;

   // status to the controller
   assign status.pending          = pending_ff;
   assign status.is_timeout       = hold_type_ff == gbn_pkg::ReqTimeout;
   assign status.is_none          = hold_type_ff == gbn_pkg::ReqNone;
   assign status.out_free         = out_free;
   assign status.none_outstanding = outstanding == '0;
   assign status.replay_last      = replay_last;

   `GBN_ASSERT_IMP(a_replay_in_window, cmd.emit_replay, XW'(rep_cnt_ff) < out_x, "replay past the outstanding packets")
   `GBN_ASSERT_IMP(a_pending_cleared, $fell(pending_ff), $past(cmd.exec_single || cmd.drop || cmd.emit_replay), "item dropped without its results")
   `GBN_ASSERT_NXT(a_replay_holds_window, cmd.rd_issue || cmd.emit_replay, $stable(base_ff) && $stable(next_seq_ff), "window moved during a replay")

endmodule

@@ sv/go_back_n_sender_window.sv @@
// Go-Back-N sender window.
// The request channel (req_if) takes one item at a time: send a payload, an
// acknowledgement, or a retransmit timer expiry. The result channel (rsp_if)
// returns the results of each item in order; the final one carries last.
// A send or an acknowledgement gives one result, loaded into the result
// register once it is free; a new item is taken only after the held one is
// done. A timer expiry with n packets outstanding replays them oldest first,
// each as one read of the packet store and then one result; the single read
// port of the store sets that pace.
// The window size register is written through the csr_ port and is only to
// be changed while no item is in flight.
// Reset clears the window pointers and the handshake state; the window size
// returns to 4. The packet store is not cleared, as only written entries
// are ever replayed.
// When the receiver stalls, the result register holds its item and one
// further request item waits in the input holding register.
module go_back_n_sender_window #(
   parameter int SEQ_COUNT     = gbn_pkg::SeqCountDef,
   parameter int PAYLOAD_WIDTH = gbn_pkg::PayloadWidthDef
) (
   input  logic                              clock,
   input  logic                              reset,
   gbn_req_if.sink                           req_if,
   gbn_rsp_if.source                         rsp_if,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gbn_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [gbn_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [gbn_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);

   logic [gbn_pkg::WindowWidth-1:0] window_size;
   gbn_pkg::gbn_cmd_type            cmd;
   gbn_pkg::gbn_status_type         status;

   // register port
   gbn_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .window_size (window_size)
   );

   // sequencing
   gbn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // window state, packet store and result register
   gbn_datapath #(
      .SEQ_COUNT     (SEQ_COUNT),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .window_size (window_size),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

@@ tb/go_back_n_sender_window_tb.sv @@
// testbench for go_back_n_sender_window: random and directed requests with a
// scoreboard that predicts every result item; needs gbn_pkg, gbn_req_if, gbn_rsp_if
`timescale 1ns / 1ps

module go_back_n_sender_window_tb;

   localparam int SeqCount    = gbn_pkg::SeqCountDef;
   localparam int DrainCycles = 24;
   localparam int CycleLimit  = 200000;
   localparam logic [gbn_pkg::CsrAddrWidth-1:0] WindowAddr =
      gbn_pkg::CsrAddrWidth'(4 * gbn_pkg::RegWindowSize);

   typedef struct packed {
      logic [1:0]                           kind;
      logic [gbn_pkg::PortPayloadWidth-1:0] payload;
      logic [gbn_pkg::SeqPortWidth-1:0]     ack_number;
      logic                                 ack_ok;
   } request_type;

   typedef struct packed {
      logic                                 accepted;
      logic                                 packet_valid;
      logic [gbn_pkg::SeqPortWidth-1:0]     packet_seq;
      logic [gbn_pkg::PortPayloadWidth-1:0] packet_payload;
      logic [1:0]                           timer_cmd;
      logic                                 last;
   } result_type;

   // sender window predictor and the results it still owes
   class window_scoreboard;
      logic [gbn_pkg::WindowWidth-1:0]      window;
      int                                   base_seq;
      int                                   next_seq;
      logic [gbn_pkg::PortPayloadWidth-1:0] sent_copy [SeqCount];
      result_type                           owed_results [$];
      int                                   fails;

      function new();
         window   = gbn_pkg::WindowReset;
         base_seq = 0;
         next_seq = 0;
         fails    = 0;
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         fails++;
      endtask

      function int in_flight();
         return (next_seq - base_seq + SeqCount) % SeqCount;
      endfunction

      function logic [gbn_pkg::SeqPortWidth-1:0] seq_at(int k);
         return gbn_pkg::SeqPortWidth'((base_seq + k) % SeqCount);
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      function void owe(logic acc, logic pv, int seq,
                        logic [gbn_pkg::PortPayloadWidth-1:0] pay,
                        logic [1:0] tcmd, logic fin);
         result_type r;
         r.accepted       = acc;
         r.packet_valid   = pv;
         r.packet_seq     = gbn_pkg::SeqPortWidth'(seq);
         r.packet_payload = pay;
         r.timer_cmd      = tcmd;
         r.last           = fin;
         owed_results.push_back(r);
      endfunction

      // advance the window state for one accepted request item
      function void apply_request(request_type req);
         int outs;
         int limit;
         int n;
         int s;
         logic [1:0] tcmd;
         outs  = in_flight();
         limit = (window > SeqCount - 1) ? SeqCount - 1 : int'(window);
         case (req.kind)
            gbn_pkg::ReqSend: begin
               if (outs >= limit) begin
                  owe(1'b0, 1'b0, 0, '0, gbn_pkg::TmrNone, 1'b1);
               end else begin
                  sent_copy[next_seq] = req.payload;
                  owe(1'b1, 1'b1, next_seq, req.payload,
                      (base_seq == next_seq) ? gbn_pkg::TmrStart : gbn_pkg::TmrNone, 1'b1);
                  next_seq = (next_seq + 1) % SeqCount;
               end
            end
            gbn_pkg::ReqAck: begin
               tcmd = gbn_pkg::TmrNone;
               if (req.ack_ok &&
                   (int'(req.ack_number) - base_seq + SeqCount) % SeqCount < outs) begin
                  base_seq = (int'(req.ack_number) + 1) % SeqCount;
                  tcmd = (base_seq == next_seq) ? gbn_pkg::TmrStop : gbn_pkg::TmrRestart;
               end
               owe(1'b0, 1'b0, 0, '0, tcmd, 1'b1);
            end
            gbn_pkg::ReqTimeout: begin
               n = (outs > gbn_pkg::MaxReplay) ? gbn_pkg::MaxReplay : outs;
               if (n == 0) owe(1'b0, 1'b0, 0, '0, gbn_pkg::TmrStop, 1'b1);
               for (int i = 0; i < n; i++) begin
                  s = (base_seq + i) % SeqCount;
                  owe(1'b0, 1'b1, s, sent_copy[s],
                      (i == n - 1) ? gbn_pkg::TmrRestart : gbn_pkg::TmrNone, i == n - 1);
               end
            end
            default: ;
         endcase
      endfunction

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      // match one result item against the oldest owed one
      task check_result(result_type got);
         result_type want;
         if (owed_results.size() == 0) begin
            report("result item with nothing expected");
            return;
         end
         want = owed_results.pop_front();
         compare_field("accepted", 32'(got.accepted), 32'(want.accepted));
         compare_field("packet_valid", 32'(got.packet_valid), 32'(want.packet_valid));
         compare_field("packet_seq", 32'(got.packet_seq), 32'(want.packet_seq));
         compare_field("packet_payload", got.packet_payload, want.packet_payload);
         compare_field("timer_cmd", 32'(got.timer_cmd), 32'(want.timer_cmd));
         compare_field("last", 32'(got.last), 32'(want.last));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [gbn_pkg::CsrAddrWidth-1:0] csr_paddr;
   logic [gbn_pkg::CsrDataWidth-1:0] csr_pwdata;
   logic [gbn_pkg::CsrDataWidth-1:0] csr_prdata;
   logic csr_pready;
   logic quiet;
   int   cycles;
   result_type seen;
   window_scoreboard sb;

   gbn_req_if req_bus ();
   gbn_rsp_if rsp_bus ();

   go_back_n_sender_window dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   always #5 clock = ~clock;

   // receiver stalls at random unless in a quiet stretch
   always @(negedge clock) begin
      rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 36);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.accepted       = rsp_bus.accepted;
         seen.packet_valid   = rsp_bus.packet_valid;
         seen.packet_seq     = rsp_bus.packet_seq;
         seen.packet_payload = rsp_bus.packet_payload;
         seen.timer_cmd      = rsp_bus.timer_cmd;
         seen.last           = rsp_bus.last;
         sb.check_result(seen);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // offer one request item and wait for it to be taken; ends at a falling edge
   task automatic drive_req(input logic [1:0] kind,
                            input logic [gbn_pkg::PortPayloadWidth-1:0] pay,
                            input logic [gbn_pkg::SeqPortWidth-1:0] ack, input logic ok);
      request_type req;
      req.kind       = kind;
      req.payload    = pay;
      req.ack_number = ack;
      req.ack_ok     = ok;
      while (!quiet && $urandom_range(0, 99) < 36) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.req_type        <= kind;
      req_bus.payload         <= pay;
      req_bus.ack_number      <= ack;
      req_bus.ack_checksum_ok <= ok;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.apply_request(req);
      @(negedge clock);
   endtask

   // mostly well-formed traffic: acks aimed at outstanding numbers
   task automatic random_req();
      int pick;
      int outs;
      logic [gbn_pkg::SeqPortWidth-1:0] ack;
      logic ok;
      pick = $urandom_range(0, 99);
      outs = sb.in_flight();
      if (pick < 45) begin
         drive_req(gbn_pkg::ReqSend, $urandom, 3'($urandom), 1'($urandom));
      end else if (pick < 75) begin
         if (outs > 0 && $urandom_range(0, 9) < 8) begin
            ack = sb.seq_at($urandom_range(0, outs - 1));
            ok  = $urandom_range(0, 9) != 0;
         end else begin
            ack = 3'($urandom);
            ok  = 1'($urandom);
         end
         drive_req(gbn_pkg::ReqAck, $urandom, ack, ok);
      end else if (pick < 93) begin
         drive_req(gbn_pkg::ReqTimeout, $urandom, 3'($urandom), 1'($urandom));
      end else begin
         drive_req(gbn_pkg::ReqNone, $urandom, 3'($urandom), 1'($urandom));
      end
   endtask

   // wait until every owed result is in and the block has settled
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic csr_read(input logic [gbn_pkg::CsrAddrWidth-1:0] addr,
                           output logic [gbn_pkg::CsrDataWidth-1:0] data);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_paddr  <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write the window size while idle and read it back
   task automatic set_window(input int value);
      logic [gbn_pkg::CsrDataWidth-1:0] rd;
      wait_drained();
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= WindowAddr;
      csr_pwdata <= gbn_pkg::CsrDataWidth'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.window = gbn_pkg::WindowWidth'(value);
      @(negedge clock);
      csr_read(WindowAddr, rd);
      if (rd !== gbn_pkg::CsrDataWidth'(value))
         sb.report($sformatf("window_size read %0h expected %0h", rd, value));
   endtask

   initial begin
      logic [gbn_pkg::CsrDataWidth-1:0] rd;
      int windows [7];
      int counts  [7];
      windows = '{7, 2, 0, 5, 1, 3, 6};
      counts  = '{25, 20, 10, 25, 20, 20, 35};
      sb = new();
      clock       = 1'b0;
      reset       = 1'b1;
      quiet       = 1'b0;
      cycles      = 0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_bus.valid           = 1'b0;
      req_bus.req_type        = gbn_pkg::ReqNone;
      req_bus.payload         = '0;
      req_bus.ack_number      = '0;
      req_bus.ack_checksum_ok = 1'b0;
      rsp_bus.ready           = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset value of the window register
      csr_read(WindowAddr, rd);
      if (rd !== gbn_pkg::CsrDataWidth'(gbn_pkg::WindowReset))
         sb.report($sformatf("window_size after reset %0h", rd));

      // empty window: timeout stops the timer, ack is ignored
      drive_req(gbn_pkg::ReqTimeout, '0, '0, 1'b0);
      drive_req(gbn_pkg::ReqAck, '0, 3'd0, 1'b1);
      // fill the reset window, then one refused send
      drive_req(gbn_pkg::ReqSend, 32'h0000_0000, '0, 1'b0);
      drive_req(gbn_pkg::ReqSend, 32'hFFFF_FFFF, 3'd7, 1'b1);
      drive_req(gbn_pkg::ReqSend, 32'hA5A5_A5A5, '0, 1'b0);
      drive_req(gbn_pkg::ReqSend, 32'h5A5A_5A5A, '0, 1'b0);
      drive_req(gbn_pkg::ReqSend, 32'h1234_5678, '0, 1'b0);
      // bad checksum, then a number outside the window
      drive_req(gbn_pkg::ReqAck, '0, sb.seq_at(1), 1'b0);
      drive_req(gbn_pkg::ReqAck, '0, 3'd7, 1'b1);
      drive_req(gbn_pkg::ReqTimeout, '0, '0, 1'b0);
      drive_req(gbn_pkg::ReqAck, '0, sb.seq_at(1), 1'b1);
      drive_req(gbn_pkg::ReqNone, $urandom, 3'($urandom), 1'($urandom));
      drive_req(gbn_pkg::ReqAck, '0, sb.seq_at(1), 1'b1);
      drive_req(gbn_pkg::ReqTimeout, '0, '0, 1'b0);

      // widest window with wrap of the sequence numbers, full replay
      set_window(7);
      repeat (7) drive_req(gbn_pkg::ReqSend, $urandom, '0, 1'b0);
      drive_req(gbn_pkg::ReqSend, $urandom, '0, 1'b0);
      drive_req(gbn_pkg::ReqTimeout, '0, '0, 1'b0);

      // shrink the window under outstanding packets
      set_window(1);
      drive_req(gbn_pkg::ReqSend, $urandom, '0, 1'b0);
      drive_req(gbn_pkg::ReqAck, '0, sb.seq_at(5), 1'b1);
      drive_req(gbn_pkg::ReqSend, $urandom, '0, 1'b0);
      drive_req(gbn_pkg::ReqAck, '0, sb.seq_at(0), 1'b1);

      // random phases over several window sizes, one without idling
      for (int p = 0; p < 7; p++) begin
         set_window(windows[p]);
         quiet = (p == 3);
         repeat (counts[p]) random_req();
      end
      quiet = 1'b0;

      wait_drained();
      if (sb.pending() != 0) sb.report("results still expected at end");
      if (sb.fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/gbn_pkg.sv
sv/gbn_req_if.sv
sv/gbn_rsp_if.sv
sv/gbn_csr.sv
sv/gbn_ctrl.sv
sv/gbn_datapath.sv
sv/go_back_n_sender_window.sv
tb/go_back_n_sender_window_tb.sv
